[rtl/i2crts_pkg.sv]
// Shared types and constants for the I2C register transfer sequencer.
package i2crts_pkg;

  localparam int BUF_DEPTH = 16;
  localparam int BUF_IDX_W = $clog2(BUF_DEPTH);
  localparam int LEN_W     = 5;
  localparam int CNT_W     = 5;
  localparam int IDX_W     = 4;

  // depth of the command queue and the result queue (power of two)
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_BEGIN  = 2'd1;
  localparam logic [1:0] FUNC_STATUS = 2'd2;

  localparam logic RW_BIT_READ = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_BEGIN,
    OP_STATUS,
    OP_NOP
  } op_e;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_REG,
    PH_DATA
  } phase_e;

  typedef enum logic [1:0] {
    ACK_KEEP,
    ACK_EN,
    ACK_DIS
  } ack_e;

  typedef struct packed {
    logic start_sent;
    logic addr_sent;
    logic tx_empty;
    logic rx_full;
  } flags_t;

  typedef struct packed {
    op_e              op;
    logic [6:0]       dev_addr;
    logic [7:0]       register_addr;
    logic [LEN_W-1:0] len;
    logic             write_dir;
    logic [7:0]       data_byte;
    logic [IDX_W-1:0] buf_index;
    flags_t           flags;
  } cmd_t;

  typedef struct packed {
    logic             dr_write_valid;
    logic [7:0]       dr_value;
    logic             set_start;
    logic             set_stop;
    ack_e             ack_action;
    logic             read_valid;
    logic [CNT_W-1:0] read_index;
    logic [7:0]       read_byte;
    logic             done;
    logic             busy;
  } res_t;

endpackage

[rtl/i2crts_front.sv]
// Front end: accepts items, decodes them into commands and queues them.
module i2crts_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic [1:0]                   func_i,
  input  logic [6:0]                   dev_addr_i,
  input  logic [7:0]                   register_addr_i,
  input  logic [i2crts_pkg::LEN_W-1:0] length_i,
  input  logic                         write_dir_i,
  input  logic [7:0]                   data_byte_i,
  input  logic [i2crts_pkg::IDX_W-1:0] buf_index_i,
  input  logic                         flag_start_sent_i,
  input  logic                         flag_addr_sent_i,
  input  logic                         flag_tx_empty_i,
  input  logic                         flag_rx_full_i,
  output logic                         cmd_valid_o,
  output i2crts_pkg::cmd_t             cmd_o,
  input  logic                         cmd_pop_i
);
  import i2crts_pkg::*;

  cmd_t              cmd_in;
  cmd_t              queue_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_push, do_pop;

  // classify the item and clamp the transfer length up front
  always_comb begin
    cmd_in               = '0;
    cmd_in.dev_addr      = dev_addr_i;
    cmd_in.register_addr = register_addr_i;
    cmd_in.write_dir     = write_dir_i;
    cmd_in.data_byte     = data_byte_i;
    cmd_in.buf_index     = buf_index_i;
    cmd_in.flags         = '{start_sent: flag_start_sent_i, addr_sent: flag_addr_sent_i,
                             tx_empty: flag_tx_empty_i, rx_full: flag_rx_full_i};
    if (length_i == '0) begin
      cmd_in.len = LEN_W'(1);
    end else if (int'(length_i) > BUF_DEPTH) begin
      cmd_in.len = LEN_W'(BUF_DEPTH);
    end else begin
      cmd_in.len = length_i;
    end
    unique case (func_i)
      FUNC_LOAD:   cmd_in.op = OP_LOAD;
      FUNC_BEGIN:  cmd_in.op = OP_BEGIN;
      FUNC_STATUS: cmd_in.op = OP_STATUS;
      default:     cmd_in.op = OP_NOP;
    endcase
  end

  assign full        = (count_q == QCNT_W'(QDEPTH));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = queue_q[rd_ptr_q];
  assign do_push     = push && !full;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      queue_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

[rtl/i2crts_back.sv]
// Back end: transfer state, write buffer, flag handling and result queue.
module i2crts_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  input  i2crts_pkg::cmd_t     cmd_i,
  output logic                 cmd_pop_o,
  output logic                 empty,
  input  logic                 pop,
  output i2crts_pkg::res_t     res_o
);
  import i2crts_pkg::*;

  phase_e            phase_q, phase_d;
  logic [6:0]        addr_q, addr_d;
  logic [7:0]        reg_q, reg_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic              wr_q, wr_d;
  logic [CNT_W-1:0]  bc_q, bc_d;
  logic [7:0]        buf_q [BUF_DEPTH];
  logic              buf_we;
  logic [CNT_W:0]    tx_idx;
  res_t              res;

  res_t              rq_q [QDEPTH];
  logic [QPTR_W-1:0] rq_wr_q, rq_rd_q;
  logic [QCNT_W-1:0] rq_cnt_q;
  logic              rq_full, rq_pop;

  assign rq_full   = (rq_cnt_q == QCNT_W'(QDEPTH));
  assign cmd_pop_o = cmd_valid_i && !rq_full;
  assign empty     = (rq_cnt_q == '0);
  assign rq_pop    = pop && !empty;
  assign res_o     = rq_q[rq_rd_q];

  // flags are taken in order start, address, tx empty, rx full; later ones win
  always_comb begin
    phase_d = phase_q;
    addr_d  = addr_q;
    reg_d   = reg_q;
    len_d   = len_q;
    wr_d    = wr_q;
    bc_d    = bc_q;
    buf_we  = 1'b0;
    tx_idx  = '0;
    res     = '0;
    if (cmd_pop_o) begin
      unique case (cmd_i.op)
        OP_LOAD: begin
          if (phase_q == PH_IDLE && int'(cmd_i.buf_index) < BUF_DEPTH) begin
            buf_we = 1'b1;
          end
        end
        OP_BEGIN: begin
          if (phase_q == PH_IDLE) begin
            phase_d       = PH_REG;
            addr_d        = cmd_i.dev_addr;
            reg_d         = cmd_i.register_addr;
            len_d         = cmd_i.len;
            wr_d          = cmd_i.write_dir;
            bc_d          = '0;
            res.set_start = 1'b1;
          end
        end
        OP_STATUS: begin
          if (phase_q != PH_IDLE) begin
            if (cmd_i.flags.start_sent) begin
              res.dr_value       = {addr_q, (wr_q || phase_d == PH_REG) ? 1'b0 : RW_BIT_READ};
              res.dr_write_valid = 1'b1;
              bc_d               = '0;
            end
            if (cmd_i.flags.addr_sent) begin
              if (phase_d == PH_REG) begin
                res.dr_value       = reg_q;
                res.dr_write_valid = 1'b1;
              end else if (wr_q) begin
                res.dr_value       = buf_q[0];
                res.dr_write_valid = 1'b1;
              end
            end
            if (cmd_i.flags.tx_empty) begin
              if (phase_d == PH_REG) begin
                res.set_start  = 1'b1;
                phase_d        = PH_DATA;
                res.ack_action = ACK_EN;
              end else if (wr_q) begin
                if ({1'b0, bc_d} == {1'b0, len_q} - (CNT_W+1)'(1)) begin
                  res.ack_action = ACK_DIS;
                  res.set_stop   = 1'b1;
                  res.done       = 1'b1;
                  phase_d        = PH_IDLE;
                end else begin
                  tx_idx = {1'b0, bc_d} + (CNT_W+1)'(1);
                  // slots past the buffer read as zero
                  if (int'(tx_idx) < BUF_DEPTH) begin
                    res.dr_value = buf_q[tx_idx[BUF_IDX_W-1:0]];
                  end else begin
                    res.dr_value = '0;
                  end
                  res.dr_write_valid = 1'b1;
                  bc_d               = tx_idx[CNT_W-1:0];
                end
              end
            end
            if (cmd_i.flags.rx_full) begin
              // length one gives all ones here and never matches
              if ({1'b0, bc_d} == {1'b0, len_q} - (CNT_W+1)'(2)) begin
                res.ack_action = ACK_DIS;
                res.set_stop   = 1'b1;
                res.done       = 1'b1;
                phase_d        = PH_IDLE;
              end else begin
                res.ack_action = ACK_EN;
              end
              res.read_valid = 1'b1;
              res.read_index = bc_d;
              res.read_byte  = cmd_i.data_byte;
              bc_d           = bc_d + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
    res.busy = (phase_d != PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      addr_q  <= '0;
      reg_q   <= '0;
      len_q   <= '0;
      wr_q    <= 1'b0;
      bc_q    <= '0;
    end else begin
      phase_q <= phase_d;
      addr_q  <= addr_d;
      reg_q   <= reg_d;
      len_q   <= len_d;
      wr_q    <= wr_d;
      bc_q    <= bc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (buf_we) begin
      buf_q[cmd_i.buf_index[BUF_IDX_W-1:0]] <= cmd_i.data_byte;
    end
  end

  // result queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rq_wr_q  <= '0;
      rq_rd_q  <= '0;
      rq_cnt_q <= '0;
    end else begin
      if (cmd_pop_o) begin
        rq_wr_q <= rq_wr_q + 1'b1;
      end
      if (rq_pop) begin
        rq_rd_q <= rq_rd_q + 1'b1;
      end
      if (cmd_pop_o && !rq_pop) begin
        rq_cnt_q <= rq_cnt_q + 1'b1;
      end else if (rq_pop && !cmd_pop_o) begin
        rq_cnt_q <= rq_cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      rq_q[rq_wr_q] <= res;
    end
  end

endmodule

[rtl/i2c_register_transfer_sequencer.sv]
// Top level of the I2C register transfer sequencer.
// Items wait in the command queue; the back end stores each result in the result queue.
// Throughput: one item per cycle; one command per cycle while the result queue has room.
// Two-entry command and result queues let each side stall without stopping the other.
// Reset (rst_ni low, asynchronous): phase idle, target fields and counter cleared,
// both queues empty; write buffer slots hold no value until loaded.
module i2c_register_transfer_sequencer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic [1:0]                   func_i,
  input  logic [6:0]                   dev_addr_i,
  input  logic [7:0]                   register_addr_i,
  input  logic [i2crts_pkg::LEN_W-1:0] length_i,
  input  logic                         write_dir_i,
  input  logic [7:0]                   data_byte_i,
  input  logic [i2crts_pkg::IDX_W-1:0] buf_index_i,
  input  logic                         flag_start_sent_i,
  input  logic                         flag_addr_sent_i,
  input  logic                         flag_tx_empty_i,
  input  logic                         flag_rx_full_i,
  output logic                         empty,
  input  logic                         pop,
  output logic                         dr_write_valid_o,
  output logic [7:0]                   dr_value_o,
  output logic                         set_start_o,
  output logic                         set_stop_o,
  output logic [1:0]                   ack_action_o,
  output logic                         read_valid_o,
  output logic [i2crts_pkg::CNT_W-1:0] read_index_o,
  output logic [7:0]                   read_byte_o,
  output logic                         done_res_o,
  output logic                         busy_res_o
);
  import i2crts_pkg::*;

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;
  res_t res;

  i2crts_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push              (push),
    .full              (full),
    .func_i            (func_i),
    .dev_addr_i        (dev_addr_i),
    .register_addr_i   (register_addr_i),
    .length_i          (length_i),
    .write_dir_i       (write_dir_i),
    .data_byte_i       (data_byte_i),
    .buf_index_i       (buf_index_i),
    .flag_start_sent_i (flag_start_sent_i),
    .flag_addr_sent_i  (flag_addr_sent_i),
    .flag_tx_empty_i   (flag_tx_empty_i),
    .flag_rx_full_i    (flag_rx_full_i),
    .cmd_valid_o       (cmd_valid),
    .cmd_o             (cmd),
    .cmd_pop_i         (cmd_pop)
  );

  i2crts_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .empty       (empty),
    .pop         (pop),
    .res_o       (res)
  );

  assign dr_write_valid_o = res.dr_write_valid;
  assign dr_value_o       = res.dr_value;
  assign set_start_o      = res.set_start;
  assign set_stop_o       = res.set_stop;
  assign ack_action_o     = res.ack_action;
  assign read_valid_o     = res.read_valid;
  assign read_index_o     = res.read_index;
  assign read_byte_o      = res.read_byte;
  assign done_res_o       = res.done;
  assign busy_res_o       = res.busy;

endmodule

[rtl/i2crts_checker.sv]
// Port-level assertions for the I2C register transfer sequencer, bound to the top level.
module i2crts_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic       dr_write_valid_o,
  input logic [7:0] dr_value_o,
  input logic       set_stop_o,
  input logic       done_res_o,
  input logic       busy_res_o
);

  // a completed transfer stops the bus and leaves the sequencer idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && done_res_o) |-> (set_stop_o && !busy_res_o))
    else $error("done without stop or idle");

  // stop is only ever requested together with completion
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && set_stop_o) |-> done_res_o)
    else $error("stop without done");

  // no data register byte is reported unless a write happens
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !dr_write_valid_o) |-> (dr_value_o == 8'd0))
    else $error("stray data register value");

  // a waiting item stays waiting until popped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("result dropped without pop");

endmodule

bind i2c_register_transfer_sequencer i2crts_checker u_i2crts_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .empty            (empty),
  .pop              (pop),
  .dr_write_valid_o (dr_write_valid_o),
  .dr_value_o       (dr_value_o),
  .set_stop_o       (set_stop_o),
  .done_res_o       (done_res_o),
  .busy_res_o       (busy_res_o)
);

[test/tb_top.sv]
// Self-checking testbench for the I2C register transfer sequencer.
`timescale 1ns / 100ps

module tb_top;
  import i2crts_pkg::*;

  localparam logic [1:0] FUNC_RESERVED = 2'd3;
  localparam int TARGET_ITEMS = 1850;
  localparam int TAIL_ITEMS   = 60;
  localparam int QUIET_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [1:0]       func;
    logic [6:0]       dev_addr;
    logic [7:0]       register_addr;
    logic [LEN_W-1:0] len_field;
    logic             write_dir;
    logic [7:0]       data_byte;
    logic [IDX_W-1:0] buf_index;
    logic             start_sent;
    logic             addr_sent;
    logic             tx_empty;
    logic             rx_full;
  } xfer_item_t;

  logic             clk_i;
  logic             rst_ni;
  logic             push;
  logic             full;
  logic [1:0]       func_i;
  logic [6:0]       dev_addr_i;
  logic [7:0]       register_addr_i;
  logic [LEN_W-1:0] length_i;
  logic             write_dir_i;
  logic [7:0]       data_byte_i;
  logic [IDX_W-1:0] buf_index_i;
  logic             flag_start_sent_i;
  logic             flag_addr_sent_i;
  logic             flag_tx_empty_i;
  logic             flag_rx_full_i;
  logic             empty;
  logic             pop;
  logic             dr_write_valid_o;
  logic [7:0]       dr_value_o;
  logic             set_start_o;
  logic             set_stop_o;
  logic [1:0]       ack_action_o;
  logic             read_valid_o;
  logic [CNT_W-1:0] read_index_o;
  logic [7:0]       read_byte_o;
  logic             done_res_o;
  logic             busy_res_o;

  // predicted sequencer state
  phase_e           seq_phase;
  logic [6:0]       seq_slave;
  logic [7:0]       seq_reg;
  logic [4:0]       seq_len;
  logic             seq_write;
  logic [4:0]       seq_count;
  logic [7:0]       seq_wbuf [BUF_DEPTH];

  res_t             expected_results [$];
  int               n_errors;
  int               n_sent;
  int               quiet_cycles;
  bit               burst_in;
  bit               burst_out;

  i2c_register_transfer_sequencer i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .func_i           (func_i),
    .dev_addr_i       (dev_addr_i),
    .register_addr_i  (register_addr_i),
    .length_i         (length_i),
    .write_dir_i      (write_dir_i),
    .data_byte_i      (data_byte_i),
    .buf_index_i      (buf_index_i),
    .flag_start_sent_i(flag_start_sent_i),
    .flag_addr_sent_i (flag_addr_sent_i),
    .flag_tx_empty_i  (flag_tx_empty_i),
    .flag_rx_full_i   (flag_rx_full_i),
    .empty            (empty),
    .pop              (pop),
    .dr_write_valid_o (dr_write_valid_o),
    .dr_value_o       (dr_value_o),
    .set_start_o      (set_start_o),
    .set_stop_o       (set_stop_o),
    .ack_action_o     (ack_action_o),
    .read_valid_o     (read_valid_o),
    .read_index_o     (read_index_o),
    .read_byte_o      (read_byte_o),
    .done_res_o       (done_res_o),
    .busy_res_o       (busy_res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [7:0] wbuf_at(int slot);
    return (slot < BUF_DEPTH) ? seq_wbuf[IDX_W'(slot)] : 8'h00;
  endfunction

  function automatic res_t step_sequencer(xfer_item_t it);
    res_t       r;
    logic [7:0] addr_byte;
    r = '0;
    case (it.func)
      FUNC_LOAD: begin
        if (seq_phase == PH_IDLE) begin
          seq_wbuf[it.buf_index] = it.data_byte;
        end
      end
      FUNC_BEGIN: begin
        if (seq_phase == PH_IDLE) begin
          if (it.len_field == 0)
            seq_len = 5'd1;
          else if (it.len_field > BUF_DEPTH)
            seq_len = 5'(BUF_DEPTH);
          else
            seq_len = it.len_field;
          seq_phase   = PH_REG;
          seq_slave   = it.dev_addr;
          seq_reg     = it.register_addr;
          seq_write   = it.write_dir;
          seq_count   = '0;
          r.set_start = 1'b1;
        end
      end
      FUNC_STATUS: begin
        if (seq_phase != PH_IDLE) begin
          // flags are taken in fixed order; later data-register writes win
          if (it.start_sent) begin
            addr_byte = {seq_slave, 1'b0};
            r.dr_value = (seq_write || seq_phase == PH_REG) ?
                         addr_byte : (addr_byte | {7'd0, RW_BIT_READ});
            r.dr_write_valid = 1'b1;
            seq_count = '0;
          end
          if (it.addr_sent) begin
            if (seq_phase == PH_REG) begin
              r.dr_value = seq_reg;
              r.dr_write_valid = 1'b1;
            end else if (seq_write) begin
              r.dr_value = wbuf_at(0);
              r.dr_write_valid = 1'b1;
            end
          end
          if (it.tx_empty) begin
            if (seq_phase == PH_REG) begin
              r.set_start = 1'b1;
              r.ack_action = ACK_EN;
              seq_phase = PH_DATA;
            end else if (seq_write) begin
              if (int'(seq_count) == int'(seq_len) - 1) begin
                r.ack_action = ACK_DIS;
                r.set_stop = 1'b1;
                r.done = 1'b1;
                seq_phase = PH_IDLE;
              end else begin
                r.dr_value = wbuf_at(int'(seq_count) + 1);
                r.dr_write_valid = 1'b1;
                seq_count = seq_count + 5'd1;
              end
            end
          end
          // receive path ignores the direction
          if (it.rx_full) begin
            if (int'(seq_count) == int'(seq_len) - 2) begin
              r.ack_action = ACK_DIS;
              r.set_stop = 1'b1;
              r.done = 1'b1;
              seq_phase = PH_IDLE;
            end else begin
              r.ack_action = ACK_EN;
            end
            r.read_valid = 1'b1;
            r.read_index = seq_count;
            r.read_byte = it.data_byte;
            seq_count = seq_count + 5'd1;
          end
        end
      end
      default: ;
    endcase
    r.busy = (seq_phase != PH_IDLE);
    return r;
  endfunction

  function automatic xfer_item_t random_item();
    logic [$bits(xfer_item_t)-1:0] raw;
    raw = $bits(xfer_item_t)'({$urandom, $urandom});
    return xfer_item_t'(raw);
  endfunction

  // never starts a one-byte read: that would leave the block busy for good
  function automatic xfer_item_t noise_item();
    xfer_item_t it;
    it = random_item();
    if (it.func == FUNC_BEGIN && !it.write_dir && it.len_field <= 1)
      it.len_field = LEN_W'($urandom_range(2, 31));
    return it;
  endfunction

  function automatic xfer_item_t status_item(bit sb, bit ad, bit txe, bit rx);
    xfer_item_t it;
    it = random_item();
    it.func = FUNC_STATUS;
    it.start_sent = sb;
    it.addr_sent = ad;
    it.tx_empty = txe;
    it.rx_full = rx;
    return it;
  endfunction

  function automatic xfer_item_t begin_item(logic [6:0] slave, logic [7:0] ra,
                                            logic [LEN_W-1:0] len, logic wr);
    xfer_item_t it;
    it = random_item();
    it.func = FUNC_BEGIN;
    it.dev_addr = slave;
    it.register_addr = ra;
    it.len_field = len;
    it.write_dir = wr;
    return it;
  endfunction

  function automatic xfer_item_t load_item(logic [IDX_W-1:0] slot, logic [7:0] value);
    xfer_item_t it;
    it = random_item();
    it.func = FUNC_LOAD;
    it.buf_index = slot;
    it.data_byte = value;
    return it;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t: MISMATCH %s", $time, msg);
    n_errors++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s: got %0h, expected %0h", name, got, want));
  endtask

  task automatic check_result(res_t want);
    check_field("dr_write_valid", 8'(dr_write_valid_o), 8'(want.dr_write_valid));
    check_field("dr_value", dr_value_o, want.dr_value);
    check_field("set_start", 8'(set_start_o), 8'(want.set_start));
    check_field("set_stop", 8'(set_stop_o), 8'(want.set_stop));
    check_field("ack_action", 8'(ack_action_o), 8'(want.ack_action));
    check_field("read_valid", 8'(read_valid_o), 8'(want.read_valid));
    check_field("read_index", 8'(read_index_o), 8'(want.read_index));
    check_field("read_byte", read_byte_o, want.read_byte);
    check_field("done_res", 8'(done_res_o), 8'(want.done));
    check_field("busy_res", 8'(busy_res_o), 8'(want.busy));
  endtask

  // called and returns at a falling edge; push stays high for a back-to-back item
  task automatic push_item(xfer_item_t it);
    int gap;
    gap = burst_in ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    func_i            <= it.func;
    dev_addr_i        <= it.dev_addr;
    register_addr_i   <= it.register_addr;
    length_i          <= it.len_field;
    write_dir_i       <= it.write_dir;
    data_byte_i       <= it.data_byte;
    buf_index_i       <= it.buf_index;
    flag_start_sent_i <= it.start_sent;
    flag_addr_sent_i  <= it.addr_sent;
    flag_tx_empty_i   <= it.tx_empty;
    flag_rx_full_i    <= it.rx_full;
    push              <= 1'b1;
    do @(posedge clk_i); while (full);
    expected_results.push_back(step_sequencer(it));
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_all_results();
    push <= 1'b0;
    do @(negedge clk_i); while (expected_results.size() != 0);
  endtask

  task automatic send_flags(bit sb, bit ad, bit txe, bit rx, bit messy);
    if (messy && $urandom_range(0, 9) == 0)
      push_item(noise_item());
    push_item(status_item(sb, ad, txe, rx));
  endtask

  // feeds the events that finish whatever transfer is running
  task automatic recover_idle();
    while (seq_phase != PH_IDLE)
      push_item(status_item(1'b0, 1'b0, seq_phase == PH_REG || seq_write,
                            seq_phase == PH_DATA && !seq_write));
  endtask

  task automatic run_transfer(logic [6:0] slave, logic [7:0] ra, logic [LEN_W-1:0] len,
                              logic wr, bit messy);
    int eff;
    eff = (len == 0) ? 1 : (len > BUF_DEPTH) ? BUF_DEPTH : int'(len);
    push_item(begin_item(slave, ra, len, wr));
    if (messy && $urandom_range(0, 3) == 0) begin
      send_flags(1, 1, 0, 0, messy);
    end else begin
      send_flags(1, 0, 0, 0, messy);
      send_flags(0, 1, 0, 0, messy);
    end
    send_flags(0, 0, 1, 0, messy);
    send_flags(1, 0, 0, 0, messy);
    send_flags(0, 1, 0, 0, messy);
    if (wr)
      repeat (eff) send_flags(0, 0, 1, 0, messy);
    else
      repeat (eff - 1) send_flags(0, 0, 0, 1, messy);
  endtask

  task automatic test_preload_buffer();
    for (int i = 0; i < BUF_DEPTH; i++)
      push_item(load_item(IDX_W'(i), (i == 0) ? 8'h00 :
                          (i == BUF_DEPTH - 1) ? 8'hFF : 8'($urandom_range(0, 255))));
  endtask

  task automatic test_idle_events();
    xfer_item_t it;
    push_item(status_item(1, 1, 1, 1));
    it = random_item();
    it.func = FUNC_RESERVED;
    push_item(it);
  endtask

  task automatic test_merged_write();
    push_item(begin_item(7'h7F, 8'hFF, 5'd2, 1'b1));
    push_item(begin_item(7'h00, 8'h00, 5'd5, 1'b0));
    push_item(load_item('0, 8'hA5));
    push_item(status_item(1, 1, 1, 0));
    push_item(status_item(1, 0, 0, 0));
    push_item(status_item(0, 1, 0, 0));
    push_item(status_item(0, 0, 1, 0));
    push_item(status_item(0, 0, 1, 0));
  endtask

  task automatic test_unit_length_write();
    run_transfer(7'h00, 8'h00, 5'd0, 1'b1, 1'b0);
    wait_all_results();
  endtask

  task automatic test_rx_outside_read();
    push_item(begin_item(7'h2A, 8'h55, 5'd3, 1'b1));
    push_item(status_item(1, 0, 0, 0));
    push_item(status_item(0, 0, 0, 1));
    push_item(status_item(0, 0, 1, 0));
    push_item(status_item(0, 0, 0, 1));
    recover_idle();
  endtask

  task automatic test_random_transfers();
    int               n_transfers;
    logic [LEN_W-1:0] len;
    logic             wr;
    n_transfers = 0;
    while (n_sent < TARGET_ITEMS - TAIL_ITEMS) begin
      burst_in = ($urandom_range(0, 4) == 0);
      recover_idle();
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 4)) push_item(noise_item());
      wr = 1'($urandom_range(0, 1));
      len = LEN_W'($urandom_range(0, 31));
      if (!wr && len <= 1)
        len = LEN_W'($urandom_range(2, 31));
      run_transfer(7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)), len, wr,
                   $urandom_range(0, 3) != 0);
      n_transfers++;
      if (n_transfers % 40 == 0)
        wait_all_results();
    end
    burst_in = 1'b0;
  endtask

  // a one-byte read never reaches its stop, so this runs last
  task automatic test_single_byte_read_lockup();
    recover_idle();
    push_item(begin_item(7'h55, 8'hAA, 5'd0, 1'b0));
    push_item(status_item(1, 0, 0, 0));
    push_item(status_item(0, 1, 0, 0));
    push_item(status_item(0, 0, 1, 0));
    push_item(status_item(1, 0, 0, 0));
    push_item(status_item(0, 1, 0, 0));
    repeat (40) push_item(status_item(0, 0, 0, 1));
    push_item(begin_item(7'h01, 8'h02, 5'd4, 1'b1));
  endtask

  initial begin : result_checker
    res_t want;
    int   stall;
    pop = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = burst_out ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = expected_results.pop_front();
        check_result(want);
      end
      if ($urandom_range(0, 63) == 0)
        burst_out = !burst_out;
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (rst_ni) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    rst_ni            = 1'b0;
    push              = 1'b0;
    func_i            = FUNC_LOAD;
    dev_addr_i        = '0;
    register_addr_i   = '0;
    length_i          = '0;
    write_dir_i       = 1'b0;
    data_byte_i       = '0;
    buf_index_i       = '0;
    flag_start_sent_i = 1'b0;
    flag_addr_sent_i  = 1'b0;
    flag_tx_empty_i   = 1'b0;
    flag_rx_full_i    = 1'b0;
    seq_phase         = PH_IDLE;
    seq_slave         = '0;
    seq_reg           = '0;
    seq_len           = '0;
    seq_write         = 1'b0;
    seq_count         = '0;
    n_errors          = 0;
    n_sent            = 0;
    quiet_cycles      = 0;
    burst_in          = 1'b0;
    burst_out         = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_preload_buffer();
    test_idle_events();
    test_merged_write();
    test_unit_length_write();
    test_rx_outside_read();
    test_random_transfers();
    test_single_byte_read_lockup();

    push <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (n_errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

[i2c_register_transfer_sequencer.f]
rtl/i2crts_pkg.sv
rtl/i2crts_front.sv
rtl/i2crts_back.sv
rtl/i2c_register_transfer_sequencer.sv
rtl/i2crts_checker.sv
test/tb_top.sv
